[design/pseudo_voigt_profile_eval_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the pseudo-Voigt profile evaluator
// Two concurrent check forms on clk, quiet while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef PSEUDO_VOIGT_PROFILE_EVAL_ASSERT_SVH
`define PSEUDO_VOIGT_PROFILE_EVAL_ASSERT_SVH

// same-cycle implication
`define PVP_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pvp: same-cycle check failed");

// next-cycle implication
`define PVP_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pvp: next-cycle check failed");

`endif

[design/pvp_pkg.sv]
// ----------------------------------------------------------------------------
// pvp_pkg
// Beat types, fixed-point constants and the exponent ROM of the evaluator.
// ----------------------------------------------------------------------------
package pvp_pkg;

	localparam int FRAC_BITS       = 16;
	localparam int EXP_TABLE_DEPTH = 256;
	localparam int EXP_IDX_W       = $clog2(EXP_TABLE_DEPTH);

	// 2^32/sqrt(2pi), 2^32/pi, 2^32/(pi*sqrt(2pi)), ln2 in Q32, log2(e) in Q30
	localparam logic [30:0] ISQ_Q32 = 31'd1713444047;
	localparam logic [30:0] IPI_Q32 = 31'd1367130551;
	localparam logic [29:0] CFX_Q32 = 30'd545406180;
	localparam logic [31:0] LN2_Q32 = 32'd2977044472;
	localparam logic [30:0] L2E_Q30 = 31'd1549082005;

	localparam logic [16:0] MIX_ONE = 17'd65536;

	typedef struct packed {
		logic signed [31:0] position;
		logic signed [31:0] center;
		logic        [30:0] width;
		logic signed [31:0] scale;
		logic        [16:0] mix;
		logic               scale_is_flux;
		logic        [7:0]  line_tag;
	} item_t;

	typedef struct packed {
		logic signed [31:0] profile_value;
		logic               overflow;
		logic        [7:0]  result_tag;
	} result_t;

	typedef logic [30:0] exp_rom_t [EXP_TABLE_DEPTH];

	// 2^(-j/DEPTH) in Q30 from a twelve-term series of exp(-y), y in Q32
	function automatic logic [30:0] exp_rom_entry(int unsigned j);
		logic [63:0]        y;
		logic [63:0]        term;
		logic [63:0]        prod;
		logic signed [63:0] sum;
		logic [63:0]        rnd;
		y    = (64'(j) * LN2_Q32) / EXP_TABLE_DEPTH;
		term = 64'd1 << 32;
		sum  = 64'sd1 <<< 32;
		for (int n = 1; n <= 12; n++) begin
			prod = term * y;
			term = (prod >> 32) / 64'(n);
			if (n % 2 == 1) begin
				sum = sum - $signed(term);
			end else begin
				sum = sum + $signed(term);
			end
		end
		rnd = $unsigned(sum) + 64'd2;
		return rnd[32:2];
	endfunction

	function automatic exp_rom_t build_exp_rom();
		exp_rom_t t;
		for (int j = 0; j < EXP_TABLE_DEPTH; j++) begin
			t[j] = exp_rom_entry(j);
		end
		return t;
	endfunction

	localparam exp_rom_t EXP_ROM = build_exp_rom();

endpackage

[design/pseudo_voigt_profile_eval.sv]
// ----------------------------------------------------------------------------
// pseudo_voigt_profile_eval
// Fully pipelined pseudo-Voigt line profile evaluator, Q16.16 in and out.
// ----------------------------------------------------------------------------
// One beat in and one beat out per clock while the receiver takes every result. An
// accepted item passes four set-up stages (difference, products, wide partial
// products, divider operands), one divider entry stage, 47 restoring divider
// stages (the flux amplitude quotient needs 47 bits; the Gaussian argument
// and Lorentzian quotients run alongside in 21 and 44 of them), eight stages
// of exponent, Gaussian product and saturation, and the output register. A
// two-entry output buffer lets one result wait while the pipeline moves on;
// input ready drops only when both entries are full. No reset sweep: the
// exponent table is a constant ROM.

`include "pseudo_voigt_profile_eval_assert.svh"

module pseudo_voigt_profile_eval (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_ready,
	input  pvp_pkg::item_t   item,
	output logic             result_valid,
	input  logic             result_ready,
	output pvp_pkg::result_t result
);
	import pvp_pkg::*;

	localparam int A_STEPS = 47;
	localparam int Z_STEPS = 21;
	localparam int L_STEPS = 44;
	localparam logic [40:0] CAP = 41'h100_0000_0000;

	typedef struct packed {
		logic [30:0] a_rem;
		logic [46:0] a_sh;
		logic [30:0] a_div;
		logic [61:0] z_rem;
		logic [20:0] z_sh;
		logic [61:0] z_div;
		logic        z_ovf;
		logic [63:0] l_rem;
		logic [43:0] l_sh;
		logic [63:0] l_div;
		logic        l_ovf;
		logic        l_post;
		logic [31:0] mag;
		logic [16:0] om;
		logic        neg;
		logic        flux;
		logic [7:0]  tag;
	} dv_t;

	// one restoring step of each divider; shift registers end up as quotients
	function automatic dv_t dv_step(dv_t x, logic do_z, logic do_l);
		logic [31:0] at;
		logic [62:0] zt;
		logic [64:0] lt;
		dv_t         y;
		y  = x;
		at = {x.a_rem, x.a_sh[46]};
		if (at >= {1'b0, x.a_div}) begin
			y.a_rem = at[30:0] - x.a_div;
			y.a_sh  = {x.a_sh[45:0], 1'b1};
		end else begin
			y.a_rem = at[30:0];
			y.a_sh  = {x.a_sh[45:0], 1'b0};
		end
		zt = {x.z_rem, x.z_sh[20]};
		if (do_z) begin
			if (zt >= {1'b0, x.z_div}) begin
				y.z_rem = zt[61:0] - x.z_div;
				y.z_sh  = {x.z_sh[19:0], 1'b1};
			end else begin
				y.z_rem = zt[61:0];
				y.z_sh  = {x.z_sh[19:0], 1'b0};
			end
		end
		lt = {x.l_rem, x.l_sh[43]};
		if (do_l) begin
			if (lt >= {1'b0, x.l_div}) begin
				y.l_rem = lt[63:0] - x.l_div;
				y.l_sh  = {x.l_sh[42:0], 1'b1};
			end else begin
				y.l_rem = lt[63:0];
				y.l_sh  = {x.l_sh[42:0], 1'b0};
			end
		end
		return y;
	endfunction

	logic en;
	logic ov_q, sv_q;
	result_t out_q, skid_q;

	assign en         = ~sv_q;
	assign item_ready = en;

	// ---- stage 1: difference, magnitudes, clamps
	logic               vld_s1;
	logic        [32:0] ad_s1;
	logic        [31:0] mag_s1;
	logic               neg_s1;
	logic        [30:0] w_s1;
	logic        [16:0] eta_s1;
	logic               flux_s1;
	logic        [7:0]  tag_s1;
	logic signed [32:0] diff;
	logic        [32:0] ad_c;

	always_comb begin
		diff = {item.position[31], item.position} - {item.center[31], item.center};
		ad_c = diff[32] ? (~diff + 33'd1) : diff;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ad_s1   <= ad_c;
			mag_s1  <= item.scale[31] ? (~item.scale + 32'd1) : item.scale;
			neg_s1  <= item.scale[31];
			w_s1    <= (item.width == '0) ? 31'd1 : item.width;
			eta_s1  <= (item.mix > MIX_ONE) ? MIX_ONE : item.mix;
			flux_s1 <= item.scale_is_flux;
			tag_s1  <= item.line_tag;
		end
	end

	// ---- stage 2: squares and scale products
	logic        vld_s2;
	logic [64:0] sq_s2;
	logic [61:0] ww_s2;
	logic [62:0] sisq_s2;
	logic [48:0] se_s2;
	logic [61:0] sipi_s2;
	logic [16:0] om_s2;
	logic [31:0] mag_s2;
	logic        neg_s2, flux_s2;
	logic [30:0] w_s2;
	logic [7:0]  tag_s2;
	logic [65:0] sq_full;

	assign sq_full = ad_s1 * ad_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			sq_s2   <= sq_full[64:0];
			ww_s2   <= w_s1 * w_s1;
			sisq_s2 <= mag_s1 * ISQ_Q32;
			se_s2   <= mag_s1 * eta_s1;
			sipi_s2 <= w_s1 * IPI_Q32;
			om_s2   <= MIX_ONE - eta_s1;
			mag_s2  <= mag_s1;
			neg_s2  <= neg_s1;
			flux_s2 <= flux_s1;
			w_s2    <= w_s1;
			tag_s2  <= tag_s1;
		end
	end

	// ---- stage 3: Lorentzian numerator partials, denominator sum
	logic        vld_s3;
	logic [62:0] pp0_s3, pp1_s3;
	logic [47:0] pp2_s3, pp3_s3;
	logic [66:0] wv_s3;
	logic [64:0] sq_s3;
	logic [61:0] ww_s3;
	logic [62:0] sisq_s3;
	logic [16:0] om_s3;
	logic [31:0] mag_s3;
	logic        neg_s3, flux_s3;
	logic [30:0] w_s3;
	logic [7:0]  tag_s3;
	logic [61:0] mul_c;

	assign mul_c = flux_s2 ? {32'd0, CFX_Q32} : sipi_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			pp0_s3  <= se_s2[31:0] * mul_c[30:0];
			pp1_s3  <= se_s2[31:0] * mul_c[61:31];
			pp2_s3  <= se_s2[48:32] * mul_c[30:0];
			pp3_s3  <= se_s2[48:32] * mul_c[61:31];
			wv_s3   <= {sq_s2, 2'b00} + {5'd0, ww_s2};
			sq_s3   <= sq_s2;
			ww_s3   <= ww_s2;
			sisq_s3 <= sisq_s2;
			om_s3   <= om_s2;
			mag_s3  <= mag_s2;
			neg_s3  <= neg_s2;
			flux_s3 <= flux_s2;
			w_s3    <= w_s2;
			tag_s3  <= tag_s2;
		end
	end

	// ---- stage 4: numerator sum and shift, denominator range fold
	logic         vld_s4;
	logic [79:0]  num_s4;
	logic [63:0]  wvp_s4;
	logic         post_s4;
	logic [64:0]  sq_s4;
	logic [61:0]  ww_s4;
	logic [62:0]  sisq_s4;
	logic [16:0]  om_s4;
	logic [31:0]  mag_s4;
	logic         neg_s4, flux_s4;
	logic [30:0]  w_s4;
	logic [7:0]   tag_s4;
	logic [110:0] nprod;

	always_comb begin
		nprod = {48'd0, pp0_s3} + ({48'd0, pp1_s3} << 31) + ({63'd0, pp2_s3} << 32)
			+ ({63'd0, pp3_s3} << 63);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_s4  <= flux_s3 ? nprod[94:15] : nprod[110:31];
			wvp_s4  <= (wv_s3[66:64] != 3'd0) ? wv_s3[66:3] : wv_s3[63:0];
			post_s4 <= (wv_s3[66:64] != 3'd0);
			sq_s4   <= sq_s3;
			ww_s4   <= ww_s3;
			sisq_s4 <= sisq_s3;
			om_s4   <= om_s3;
			mag_s4  <= mag_s3;
			neg_s4  <= neg_s3;
			flux_s4 <= flux_s3;
			w_s4    <= w_s3;
			tag_s4  <= tag_s3;
		end
	end

	// ---- stage 5 onwards: divider entry and restoring steps
	dv_t              dv_s [A_STEPS+1];
	logic [A_STEPS:0] dv_v;
	dv_t              dv_init;

	always_comb begin
		dv_init        = '0;
		dv_init.a_rem  = '0;
		dv_init.a_sh   = sisq_s4[62:16];
		dv_init.a_div  = w_s4;
		dv_init.z_rem  = {3'd0, sq_s4[64:6]};
		dv_init.z_sh   = {sq_s4[5:0], 15'd0};
		dv_init.z_div  = ww_s4;
		dv_init.z_ovf  = ({3'd0, sq_s4[64:6]} >= ww_s4);
		dv_init.l_rem  = {28'd0, num_s4[79:44]};
		dv_init.l_sh   = num_s4[43:0];
		dv_init.l_div  = wvp_s4;
		dv_init.l_ovf  = ({28'd0, num_s4[79:44]} >= wvp_s4);
		dv_init.l_post = post_s4;
		dv_init.mag    = mag_s4;
		dv_init.om     = om_s4;
		dv_init.neg    = neg_s4;
		dv_init.flux   = flux_s4;
		dv_init.tag    = tag_s4;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dv_s[0] <= dv_init;
		end
	end

	for (genvar i = 0; i < A_STEPS; i++) begin : g_div
		always_ff @(posedge clk) begin
			if (en) begin
				dv_s[i+1] <= dv_step(dv_s[i], 1'(i < Z_STEPS), 1'(i < L_STEPS));
			end
		end
	end

	// ---- stage 6: amplitude select, exponent product, Lorentzian cap
	logic        vld_s6;
	logic [51:0] ev_s6;
	logic        zovf_s6;
	logic [46:0] amp_s6;
	logic [16:0] om_s6;
	logic [40:0] rl_s6;
	logic        neg_s6;
	logic [7:0]  tag_s6;
	dv_t         dq;
	logic [43:0] lq;

	always_comb begin
		dq = dv_s[A_STEPS];
		lq = dq.l_post ? {3'd0, dq.l_sh[43:3]} : dq.l_sh;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ev_s6   <= dq.z_sh * L2E_Q30;
			zovf_s6 <= dq.z_ovf;
			amp_s6  <= dq.flux ? dq.a_sh : {15'd0, dq.mag};
			om_s6   <= dq.om;
			rl_s6   <= (dq.l_ovf || lq > {3'd0, CAP}) ? CAP : lq[40:0];
			neg_s6  <= dq.neg;
			tag_s6  <= dq.tag;
		end
	end

	// ---- stage 7: split exponent into shift, ROM index and residue
	logic                 vld_s7;
	logic [5:0]           k_s7;
	logic [EXP_IDX_W-1:0] j_s7;
	logic [61:0]          yp_s7;
	logic                 zovf_s7;
	logic [46:0]          amp_s7;
	logic [16:0]          om_s7;
	logic [40:0]          rl_s7;
	logic                 neg_s7;
	logic [7:0]           tag_s7;

	always_ff @(posedge clk) begin
		if (en) begin
			k_s7    <= ev_s6[51:46];
			j_s7    <= ev_s6[45:46-EXP_IDX_W];
			yp_s7   <= ev_s6[45-EXP_IDX_W:8] * LN2_Q32;
			zovf_s7 <= zovf_s6;
			amp_s7  <= amp_s6;
			om_s7   <= om_s6;
			rl_s7   <= rl_s6;
			neg_s7  <= neg_s6;
			tag_s7  <= tag_s6;
		end
	end

	// ---- stage 8: residue polynomial and table lookup
	logic        vld_s8;
	logic [30:0] p_s8;
	logic [30:0] tj_s8;
	logic [5:0]  k_s8;
	logic        zovf_s8;
	logic [46:0] amp_s8;
	logic [16:0] om_s8;
	logic [40:0] rl_s8;
	logic        neg_s8;
	logic [7:0]  tag_s8;
	logic [21:0] y30;
	logic [43:0] ysq;

	always_comb begin
		y30 = yp_s7[61:40];
		ysq = y30 * y30;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s8    <= {1'b1, 30'd0} - {9'd0, y30} + {18'd0, ysq[43:31]};
			tj_s8   <= EXP_ROM[j_s7];
			k_s8    <= k_s7;
			zovf_s8 <= zovf_s7;
			amp_s8  <= amp_s7;
			om_s8   <= om_s7;
			rl_s8   <= rl_s7;
			neg_s8  <= neg_s7;
			tag_s8  <= tag_s7;
		end
	end

	// ---- stage 9: table value times residue factor
	logic        vld_s9;
	logic [30:0] ef_s9;
	logic [5:0]  k_s9;
	logic        zovf_s9;
	logic [46:0] amp_s9;
	logic [16:0] om_s9;
	logic [40:0] rl_s9;
	logic        neg_s9;
	logic [7:0]  tag_s9;
	logic [61:0] efp;

	assign efp = tj_s8 * p_s8;

	always_ff @(posedge clk) begin
		if (en) begin
			ef_s9   <= efp[60:30];
			k_s9    <= k_s8;
			zovf_s9 <= zovf_s8;
			amp_s9  <= amp_s8;
			om_s9   <= om_s8;
			rl_s9   <= rl_s8;
			neg_s9  <= neg_s8;
			tag_s9  <= tag_s8;
		end
	end

	// ---- stage 10: binary shift, Gaussian weight
	logic        vld_s10;
	logic [47:0] x_s10;
	logic [46:0] amp_s10;
	logic [40:0] rl_s10;
	logic        neg_s10;
	logic [7:0]  tag_s10;
	logic [30:0] e_val;

	assign e_val = (zovf_s9 || k_s9 > 6'd30) ? 31'd0 : (ef_s9 >> k_s9);

	always_ff @(posedge clk) begin
		if (en) begin
			x_s10   <= om_s9 * e_val;
			amp_s10 <= amp_s9;
			rl_s10  <= rl_s9;
			neg_s10 <= neg_s9;
			tag_s10 <= tag_s9;
		end
	end

	// ---- stage 11: Gaussian product partials
	logic        vld_s11;
	logic [63:0] q0_s11;
	logic [47:0] q1_s11;
	logic [46:0] q2_s11;
	logic [30:0] q3_s11;
	logic [40:0] rl_s11;
	logic        neg_s11;
	logic [7:0]  tag_s11;

	always_ff @(posedge clk) begin
		if (en) begin
			q0_s11  <= amp_s10[31:0] * x_s10[31:0];
			q1_s11  <= amp_s10[31:0] * x_s10[47:32];
			q2_s11  <= amp_s10[46:32] * x_s10[31:0];
			q3_s11  <= amp_s10[46:32] * x_s10[47:32];
			rl_s11  <= rl_s10;
			neg_s11 <= neg_s10;
			tag_s11 <= tag_s10;
		end
	end

	// ---- stage 12: Gaussian sum, scale down, cap
	logic        vld_s12;
	logic [40:0] rg_s12;
	logic [40:0] rl_s12;
	logic        neg_s12;
	logic [7:0]  tag_s12;
	logic [94:0] gprod;

	always_comb begin
		gprod = {31'd0, q0_s11} + ({47'd0, q1_s11} << 32) + ({48'd0, q2_s11} << 32)
			+ ({64'd0, q3_s11} << 64);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rg_s12  <= (gprod[94:46] > {8'd0, CAP}) ? CAP : gprod[86:46];
			rl_s12  <= rl_s11;
			neg_s12 <= neg_s11;
			tag_s12 <= tag_s11;
		end
	end

	// ---- stage 13: add parts, saturate, apply sign
	logic        vld_s13;
	result_t     res_s13;
	logic [41:0] msum;
	logic [41:0] lim;
	logic        sat;
	logic [31:0] mclip;

	always_comb begin
		msum  = {1'b0, rg_s12} + {1'b0, rl_s12};
		lim   = neg_s12 ? 42'h0_8000_0000 : 42'h0_7FFF_FFFF;
		sat   = (msum > lim);
		mclip = sat ? lim[31:0] : msum[31:0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s13.profile_value <= neg_s12 ? (~mclip + 32'd1) : mclip;
			res_s13.overflow      <= sat;
			res_s13.result_tag    <= tag_s12;
		end
	end

	// ---- valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			vld_s4  <= 1'b0;
			dv_v    <= '0;
			vld_s6  <= 1'b0;
			vld_s7  <= 1'b0;
			vld_s8  <= 1'b0;
			vld_s9  <= 1'b0;
			vld_s10 <= 1'b0;
			vld_s11 <= 1'b0;
			vld_s12 <= 1'b0;
			vld_s13 <= 1'b0;
		end else if (en) begin
			vld_s1  <= item_valid;
			vld_s2  <= vld_s1;
			vld_s3  <= vld_s2;
			vld_s4  <= vld_s3;
			dv_v    <= {dv_v[A_STEPS-1:0], vld_s4};
			vld_s6  <= dv_v[A_STEPS];
			vld_s7  <= vld_s6;
			vld_s8  <= vld_s7;
			vld_s9  <= vld_s8;
			vld_s10 <= vld_s9;
			vld_s11 <= vld_s10;
			vld_s12 <= vld_s11;
			vld_s13 <= vld_s12;
		end
	end

	// ---- output register with skid entry
	logic pop, push;

	assign pop  = ov_q & result_ready;
	assign push = en & vld_s13;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
			sv_q <= 1'b0;
		end else if (pop) begin
			if (sv_q) begin
				sv_q <= 1'b0;
			end else begin
				ov_q <= push;
			end
		end else if (push) begin
			if (ov_q) begin
				sv_q <= 1'b1;
			end else begin
				ov_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (sv_q) begin
				out_q <= skid_q;
			end else if (push) begin
				out_q <= res_s13;
			end
		end else if (push) begin
			if (ov_q) begin
				skid_q <= res_s13;
			end else begin
				out_q <= res_s13;
			end
		end
	end

	assign result_valid = ov_q;
	assign result       = out_q;

	// ---- checks
	`PVP_ASSERT_IMP(a_skid_behind_out, sv_q, ov_q)
	`PVP_ASSERT_NXT(a_stall_fills_skid, ov_q && !result_ready && !sv_q && vld_s13, sv_q)
	`PVP_ASSERT_NXT(a_div_exit_valid, en && dv_v[A_STEPS], vld_s6)
	`PVP_ASSERT_IMP(a_sat_at_bound, result_valid && result.overflow,
		result.profile_value == 32'sh7FFFFFFF || result.profile_value == 32'sh80000000)

endmodule

[tb/sv/tb_pseudo_voigt_profile_eval.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_pseudo_voigt_profile_eval
// Self-checking bench for the pseudo-Voigt evaluator: directed corner items,
// then random items under several sender and receiver idling mixes, with a
// long receiver hold-off that fills the pipeline. Every result beat is
// compared field by field with a bit-exact integer prediction.
// ----------------------------------------------------------------------------
module tb_pseudo_voigt_profile_eval;
	import pvp_pkg::*;

	logic    clk;
	logic    arst_n;
	logic    item_valid;
	logic    item_ready;
	item_t   item;
	logic    result_valid;
	logic    result_ready;
	result_t result;

	result_t expected_profiles[$];
	int      send_idle_pct;
	int      recv_stall_pct;
	int      hold_reqs;
	int      hold_seen;
	int      hold_left;
	int      n_errors = 0;
	int      n_items;
	int      n_results = 0;
	int      n_flux;
	int      n_sat = 0;

	pseudo_voigt_profile_eval dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	// 10 ns clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// 2^(-j/DEPTH) in Q30 via a twelve-term series of exp(-y)
	function automatic logic [63:0] pow2_neg_q30(logic [63:0] j);
		logic [63:0]        y;
		logic [63:0]        term;
		logic signed [63:0] acc;
		y    = (j * 64'd2977044472) / 64'(EXP_TABLE_DEPTH);
		term = 64'd1 << 32;
		acc  = 64'sd1 <<< 32;
		for (int n = 1; n <= 12; n++) begin
			term = ((term * y) >> 32) / 64'(n);
			if (n % 2 == 1) begin
				acc = acc - $signed(term);
			end else begin
				acc = acc + $signed(term);
			end
		end
		return ($unsigned(acc) + 64'd2) >> 2;
	endfunction

	// exp(-z) in Q30, z in Q16 below 32
	function automatic logic [63:0] exp_neg_q30(logic [63:0] z);
		logic [63:0] v;
		logic [63:0] k;
		logic [63:0] gd;
		logic [63:0] j;
		logic [63:0] r;
		logic [63:0] y30;
		logic [63:0] p;
		logic [63:0] m46;
		m46 = (64'd1 << 46) - 64'd1;
		v   = z * 64'd1549082005;
		k   = v >> 46;
		if (k > 64'd30) begin
			return 64'd0;
		end
		gd  = (v & m46) * 64'(EXP_TABLE_DEPTH);
		j   = gd >> 46;
		r   = gd & m46;
		y30 = (((r >> 16) * 64'd2977044472) >> 32) / 64'(EXP_TABLE_DEPTH);
		p   = (64'd1 << 30) - y30 + ((y30 * y30) >> 31);
		return ((pow2_neg_q30(j) * p) >> 30) >> k;
	endfunction

	// bit-exact profile value of one item
	function automatic result_t predict_profile(item_t it);
		logic signed [32:0] d;
		logic [63:0]        ad;
		logic [63:0]        s;
		logic [63:0]        mag;
		logic [63:0]        eta;
		logic [63:0]        amp;
		logic [63:0]        ex;
		logic [63:0]        lim;
		logic [63:0]        m;
		logic [63:0]        cg;
		logic [63:0]        cl;
		logic [127:0]       sq;
		logic [127:0]       z;
		logic [127:0]       rg;
		logic [127:0]       num;
		logic [127:0]       wv;
		logic [127:0]       rl;
		logic [127:0]       cap;
		int                 post;
		logic               neg;
		result_t            res;
		d   = {it.position[31], it.position} - {it.center[31], it.center};
		ad  = d[32] ? 64'(-d) : 64'(d);
		neg = it.scale[31];
		mag = neg ? (64'd0 - {{32{1'b1}}, it.scale}) : {32'd0, it.scale};
		s   = {33'd0, it.width};
		if (s == 64'd0) begin
			s = 64'd1;
		end
		eta = {47'd0, it.mix};
		if (eta > 64'(MIX_ONE)) begin
			eta = 64'(MIX_ONE);
		end
		sq = 128'(ad) * 128'(ad);
		cap = 128'd1 << 40;

		// Gaussian part
		z  = (sq << 15) / 128'(s * s);
		ex = 64'd0;
		if (z < (128'd32 << 16)) begin
			ex = exp_neg_q30(z[63:0]);
		end
		amp = it.scale_is_flux ? ((mag * 64'd1713444047) >> 16) / s : mag;
		rg  = (128'(amp) * 128'((64'd65536 - eta) * ex)) >> 46;

		// Lorentzian part
		if (it.scale_is_flux) begin
			num = (128'(mag * eta) * 128'(64'd545406180)) >> 15;
		end else begin
			num = (128'(mag * eta) * 128'(s * 64'd1367130551)) >> 31;
		end
		wv   = (sq << 2) + 128'(s * s);
		post = 0;
		if (wv[127:64] != 64'd0) begin
			wv   = wv >> 3;
			post = 3;
		end
		rl = (num / 128'(wv[63:0])) >> post;

		// sum, saturate, restore sign
		cg  = (rg > cap) ? cap[63:0] : rg[63:0];
		cl  = (rl > cap) ? cap[63:0] : rl[63:0];
		m   = cg + cl;
		lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
		res.overflow = (m > lim);
		if (m > lim) begin
			m = lim;
		end
		res.profile_value = neg ? 32'(64'd0 - m) : m[31:0];
		res.result_tag    = it.line_tag;
		return res;
	endfunction

	// offer one beat, with random idle cycles ahead of it
	task automatic send_item(item_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		item       <= it;
		do begin
			@(posedge clk);
		end while (!item_ready);
		expected_profiles.push_back(predict_profile(it));
		n_items++;
		if (it.scale_is_flux) begin
			n_flux++;
		end
	endtask

	function automatic item_t make_item(logic signed [31:0] pos, logic signed [31:0] ctr,
			logic [30:0] wid, logic signed [31:0] scl, logic [16:0] mx, logic flux,
			logic [7:0] tag);
		item_t it;
		it.position      = pos;
		it.center        = ctr;
		it.width         = wid;
		it.scale         = scl;
		it.mix           = mx;
		it.scale_is_flux = flux;
		it.line_tag      = tag;
		return it;
	endfunction

	// random item, weighted towards offsets near the line where both parts matter
	function automatic item_t random_item();
		item_t it;
		logic [31:0] off;
		it.center = $urandom;
		it.width  = 31'($urandom) >> $urandom_range(30);
		if ($urandom_range(19) == 0) begin
			it.width = '0;
		end
		off = $urandom_range(3) == 0 ? $urandom
				: 32'($urandom_range(6) * it.width) + ($urandom >> $urandom_range(31));
		if ($urandom_range(1)) begin
			off = -off;
		end
		it.position = it.center + off;
		it.scale    = $urandom >> ($urandom_range(3) == 0 ? 0 : $urandom_range(24));
		if ($urandom_range(1)) begin
			it.scale = -it.scale;
		end
		case ($urandom_range(4))
			0: it.mix = '0;
			1: it.mix = MIX_ONE;
			2: it.mix = 17'($urandom);
			default: it.mix = 17'($urandom_range(65536));
		endcase
		it.scale_is_flux = 1'($urandom_range(1));
		it.line_tag      = 8'($urandom);
		return it;
	endfunction

	// drive the receiver side; a requested hold-off wins over random stalls
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ready <= 1'b0;
			hold_left    <= 0;
			hold_seen    <= 0;
		end else if (hold_reqs != hold_seen) begin
			result_ready <= 1'b0;
			hold_left    <= 300;
			hold_seen    <= hold_reqs;
		end else if (hold_left > 0) begin
			result_ready <= 1'b0;
			hold_left    <= hold_left - 1;
		end else begin
			result_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// compare each result beat with the oldest prediction
	always @(posedge clk) begin
		result_t want;
		if (arst_n && result_valid && result_ready) begin
			n_results++;
			if (expected_profiles.size() == 0) begin
				$error("unexpected result beat: value %0d tag %0d",
					result.profile_value, result.result_tag);
				n_errors++;
			end else begin
				want = expected_profiles.pop_front();
				if (result.overflow) begin
					n_sat++;
				end
				if (result.profile_value !== want.profile_value) begin
					$error("profile_value: expected %0d, got %0d",
						want.profile_value, result.profile_value);
					n_errors++;
				end
				if (result.overflow !== want.overflow) begin
					$error("overflow: expected %0b, got %0b", want.overflow, result.overflow);
					n_errors++;
				end
				if (result.result_tag !== want.result_tag) begin
					$error("result_tag: expected %0d, got %0d",
						want.result_tag, result.result_tag);
					n_errors++;
				end
			end
		end
	end

	task automatic test_corners();
		send_item(make_item(0, 0, 31'h10000, 32'h10000, 0, 0, 8'd0));
		send_item(make_item(0, 0, 31'h10000, 32'h10000, MIX_ONE, 0, 8'd1));
		send_item(make_item(0, 0, 31'h10000, 32'h10000, 17'd32768, 1, 8'd2));
		send_item(make_item(32'h7FFF_FFFF, 32'h8000_0000, 31'h7FFF_FFFF, 32'h7FFF_FFFF,
			17'd32768, 0, 8'd255));
		send_item(make_item(32'h8000_0000, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 32'h8000_0000,
			MIX_ONE, 1, 8'd254));
		send_item(make_item(32'h7FFF_FFFF, 32'h8000_0000, 31'd1, 32'h7FFF_FFFF, MIX_ONE, 0, 8'd3));
		// zero width
		send_item(make_item(0, 0, 0, 32'h10000, 17'd1000, 0, 8'd4));
		send_item(make_item(5, 0, 0, 32'h10000, 0, 1, 8'd5));
		// mix above one
		send_item(make_item(32'h8000, 0, 31'h10000, 32'h20000, 17'h1FFFF, 0, 8'd6));
		send_item(make_item(32'h8000, 0, 31'h10000, 32'h20000, 17'd65537, 1, 8'd7));
		// saturation, both signs
		send_item(make_item(0, 0, 31'd1, 32'h7FFF_FFFF, 0, 1, 8'd8));
		send_item(make_item(0, 0, 31'd1, 32'h8000_0000, 0, 1, 8'd9));
		send_item(make_item(0, 0, 31'd1, 32'h8000_0000, MIX_ONE, 0, 8'd10));
		send_item(make_item(0, 0, 31'h100, 32'h7FFF_FFFF, 0, 0, 8'd11));
		// negative results truncate towards zero
		send_item(make_item(32'h30000, 0, 31'h10000, -32'sd3, 17'd40000, 0, 8'd12));
		send_item(make_item(32'h18000, 32'h8000, 31'h8000, -32'sd65536, 17'd20000, 1, 8'd13));
		// Gaussian tail edge and far tail
		send_item(make_item(32'h80000, 0, 31'h10000, 32'h7FFF_FFFF, 0, 0, 8'd14));
		send_item(make_item(32'h7FFFF, 0, 31'h10000, 32'h7FFF_FFFF, 0, 0, 8'd15));
		send_item(make_item(32'h100000, 0, 31'h10000, 32'h7FFF_FFFF, 17'd1, 0, 8'd16));
		send_item(make_item(-32'sd1, 32'sd1, 31'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 1, 8'd17));
		send_item(make_item(0, 0, 31'h10000, 0, 17'd30000, 1, 8'd200));
	endtask

	task automatic test_random(int count, int idle_pct, int stall_pct);
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		repeat (count) begin
			send_item(random_item());
		end
	endtask

	// hold the receiver off long enough that the input stalls
	task automatic test_backpressure();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_reqs++;
		repeat (120) begin
			send_item(random_item());
		end
	endtask

	initial begin
		arst_n         = 1'b0;
		item_valid     = 1'b0;
		item           = '0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_reqs      = 0;
		n_items        = 0;
		n_flux         = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_corners();
		test_random(300, 0, 0);
		test_random(250, 66, 0);
		test_random(250, 0, 66);
		test_random(250, 35, 35);
		test_backpressure();
		test_random(100, 0, 0);
		item_valid <= 1'b0;

		// drain, then allow the pipeline latency for stray beats
		while (expected_profiles.size() != 0) begin
			@(posedge clk);
		end
		repeat (100) @(posedge clk);

		$display("%0d items sent, %0d results checked (%0d flux mode, %0d saturated),",
			n_items, n_results, n_flux, n_sat);
		$display("across corner cases, idling mixes and a long output hold-off");
		if (n_errors == 0 && expected_profiles.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

	// watchdog
	initial begin
		#100_000_000;
		$display("tb: failure");
		$finish;
	end

endmodule

[files.f]
+incdir+design
design/pvp_pkg.sv
design/pseudo_voigt_profile_eval.sv
tb/sv/tb_pseudo_voigt_profile_eval.sv
